@@ rtl/iphc_pkg.sv @@
// Shared types and constants for the interval partition helper counter.
// Used by every module of the block but iphc_ram; depends on nothing.
package iphc_pkg;

  localparam int TIME_W         = 16;
  localparam int COUNT_W        = 7;
  localparam int COUNT_MAX      = 127;
  localparam int HEAP_DEPTH_DEF = 64;

  // One input item: an interval of the current case.
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              first_event;
  } iphc_in_t;

  // One result item.
  typedef struct packed {
    logic [COUNT_W-1:0] helpers_needed;
    logic               overflow;
  } iphc_out_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FIRST,
    OP_OWNER,
    OP_OVF,
    OP_DOWN_INIT,
    OP_PUSH_INIT,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_DN_STEP,
    OP_RD_PARENT,
    OP_UP_STEP
  } iphc_op_t;

  typedef struct packed {
    logic     load;
    iphc_op_t op;
  } iphc_cmd_t;

  typedef struct packed {
    logic is_first;
    logic owner_free;
    logic can_replace;
    logic can_push;
    logic left_ok;
    logic pos_zero;
    logic dn_move;
    logic up_move;
  } iphc_status_t;

endpackage

@@ rtl/iphc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the helper heap; depends on nothing.
module iphc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/iphc_ctrl.sv @@
// Controller state machine for the helper counter.
// Depends on iphc_pkg for the command and status types.
module iphc_ctrl import iphc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  iphc_status_t status,
  output iphc_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECIDE   = 8'b0000_0010,
    S_DN_LEFT  = 8'b0000_0100,
    S_DN_RIGHT = 8'b0000_1000,
    S_DN_STEP  = 8'b0001_0000,
    S_UP_READ  = 8'b0010_0000,
    S_UP_STEP  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.is_first) begin
          cmd.op     = OP_FIRST;
          state_next = S_DONE;
        end else if (status.owner_free) begin
          cmd.op     = OP_OWNER;
          state_next = S_DONE;
        end else if (status.can_replace) begin
          cmd.op     = OP_DOWN_INIT;
          state_next = S_DN_LEFT;
        end else if (status.can_push) begin
          cmd.op     = OP_PUSH_INIT;
          state_next = S_UP_READ;
        end else begin
          cmd.op     = OP_OVF;
          state_next = S_DONE;
        end
      end
      S_DN_LEFT: begin
        cmd.op     = OP_RD_LEFT;
        state_next = status.left_ok ? S_DN_RIGHT : S_DONE;
      end
      S_DN_RIGHT: begin
        cmd.op     = OP_RD_RIGHT;
        state_next = S_DN_STEP;
      end
      S_DN_STEP: begin
        cmd.op     = OP_DN_STEP;
        state_next = status.dn_move ? S_DN_LEFT : S_DONE;
      end
      S_UP_READ: begin
        cmd.op     = OP_RD_PARENT;
        state_next = status.pos_zero ? S_DONE : S_UP_STEP;
      end
      S_UP_STEP: begin
        cmd.op     = OP_UP_STEP;
        state_next = status.up_move ? S_UP_READ : S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

@@ rtl/iphc_dp.sv @@
// Datapath for the helper counter: owner end, heap size, sift registers
// and the heap RAM. Depends on iphc_pkg and iphc_ram.
module iphc_dp import iphc_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  iphc_in_t     request,
  input  iphc_cmd_t    cmd,
  output iphc_status_t status,
  output iphc_out_t    result
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = AW + 2;
  localparam int SW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [TIME_W-1:0] start_q, end_q, owner_end, top_val, val, lv;
  logic              first_q, ovf;
  logic [CW-1:0]     heap_size;
  logic [AW-1:0]     pos, parent, m_idx, raddr, waddr;
  logic [XW-1:0]     l_idx, r_idx, size_x;
  logic              l_ok, r_ok, moved, up_move, we;
  logic [TIME_W-1:0] best, wdata, rdata;
  logic [SW-1:0]     size_ext;
  logic [COUNT_W-1:0] shown;

  assign l_idx  = XW'({pos, 1'b1});
  assign r_idx  = l_idx + XW'(1);
  assign size_x = XW'(heap_size);
  assign l_ok   = (l_idx < size_x);
  assign r_ok   = (r_idx < size_x);
  assign parent = AW'((pos - AW'(1)) >> 1);

  // Smallest of the hole value and its children; left wins ties with right.
  always_comb begin
    best  = val;
    m_idx = pos;
    moved = 1'b0;
    if (l_ok && (lv < best)) begin
      best  = lv;
      m_idx = l_idx[AW-1:0];
      moved = 1'b1;
    end
    if (r_ok && (rdata < best)) begin
      best  = rdata;
      m_idx = r_idx[AW-1:0];
      moved = 1'b1;
    end
  end

  assign up_move = !(rdata <= val);

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pos;
    wdata = val;
    case (cmd.op)
      OP_RD_LEFT: begin
        raddr = l_idx[AW-1:0];
        we    = !l_ok;
      end
      OP_RD_RIGHT:  raddr = r_idx[AW-1:0];
      OP_DN_STEP: begin
        we    = 1'b1;
        wdata = best;
      end
      OP_RD_PARENT: begin
        raddr = parent;
        we    = (pos == '0);
      end
      OP_UP_STEP: begin
        we    = 1'b1;
        wdata = up_move ? rdata : val;
      end
      default: ;
    endcase
  end

  iphc_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control state of the case.
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_end <= '0;
      heap_size <= '0;
      ovf       <= 1'b0;
    end else begin
      case (cmd.op)
        OP_FIRST: begin
          owner_end <= end_q;
          heap_size <= '0;
          ovf       <= 1'b0;
        end
        OP_OWNER:     owner_end <= end_q;
        OP_OVF:       ovf <= 1'b1;
        OP_PUSH_INIT: heap_size <= heap_size + CW'(1);
        default: ;
      endcase
    end
  end

  // Payload and sift registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_q <= request.start_time;
      end_q   <= request.end_time;
      first_q <= request.first_event;
    end
    case (cmd.op)
      OP_DOWN_INIT: begin
        pos <= '0;
        val <= end_q;
      end
      OP_PUSH_INIT: begin
        pos <= heap_size[AW-1:0];
        val <= end_q;
      end
      OP_RD_RIGHT: lv <= rdata;
      OP_DN_STEP: begin
        if (moved) begin
          pos <= m_idx;
        end
      end
      OP_UP_STEP: begin
        if (up_move) begin
          pos <= parent;
        end
      end
      default: ;
    endcase
    // Copy of the heap root so the decision needs no RAM read.
    if (we && (waddr == '0)) begin
      top_val <= wdata;
    end
  end

  assign status.is_first    = first_q;
  assign status.owner_free  = (start_q >= owner_end);
  assign status.can_replace = (heap_size != '0) && (top_val <= start_q);
  assign status.can_push    = (heap_size < CW'(HEAP_DEPTH));
  assign status.left_ok     = l_ok;
  assign status.pos_zero    = (pos == '0);
  assign status.dn_move     = moved;
  assign status.up_move     = up_move;

  assign size_ext = SW'(heap_size);
  assign shown    = (size_ext > SW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : COUNT_W'(size_ext);

  assign result.helpers_needed = shown;
  assign result.overflow       = ovf;

endmodule

@@ rtl/interval_partition_helper_count_core.sv @@
// Top level of the interval partition helper counter.
// Depends on iphc_pkg, iphc_ctrl and iphc_dp (which holds iphc_ram).
//
//   Channel   Handshake        Payload     Meaning
//   input     start / busy     request     one interval, accepted on start && !busy
//   output    done (strobe)    result      helper count and overflow flag
//
// Each item produces exactly one result item, shown for the single cycle in
// which done is high. A first interval, an interval the owner takes, or an
// overflow is decided in S_DECIDE and then shown in S_DONE. A replacement of
// the heap root sifts down through S_DN_LEFT, S_DN_RIGHT and S_DN_STEP per
// level, a push sifts up through S_UP_READ and S_UP_STEP per level; the single
// read port of the heap RAM sets that pace. The next item can be accepted
// in the cycle after the done cycle at the earliest.
// Reset is synchronous and clears the owner end, heap size and overflow flag;
// the heap RAM needs no clearing since only entries below the size are read.
// The receiver cannot stall; busy stays high until the done cycle has passed.
module interval_partition_helper_count_core import iphc_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  iphc_in_t  request,
  output logic      busy,
  output logic      done,
  output iphc_out_t result
);

  iphc_cmd_t    cmd;
  iphc_status_t status;

  // The controller sequences the decision and the sift steps.
  iphc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The datapath keeps the case state and the heap itself.
  iphc_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

endmodule

@@ rtl/iphc_checker.sv @@
// Port-level checks of the helper counter and their binding to the top.
// Depends on iphc_pkg and interval_partition_helper_count_core.
module iphc_checker import iphc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input iphc_out_t result
);

  // A result is only shown while an item is in work.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // An accepted item makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");

  // With no item in work and none accepted, the result stays put.
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> $stable(result))
    else $error("result changed while idle");

endmodule

bind interval_partition_helper_count_core iphc_checker u_chk (.*);
